@@ src/erm_pkg.sv @@
// Shared types and constants for the Euler-angle rotation matrix block.
// Holds the angle and matrix word structs, the quarter-wave sine coefficients
// and the pipeline stage count. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package erm_pkg;

  // Binary angle width (one turn = 2^ANGLE_BITS) and output fraction bits
  localparam int ANGLE_BITS = 16;
  localparam int FRAC_BITS  = 14;
  localparam int ENTRY_BITS = FRAC_BITS + 2;

  // 1.0 in the output format
  localparam logic signed [ENTRY_BITS-1:0] ENTRY_ONE = ENTRY_BITS'(1) <<< FRAC_BITS;

  // Odd polynomial for sin(pi/2 * u), Q30 coefficients, lowest order first
  localparam int SINE_TERMS = 7;
  localparam logic signed [31:0] SINE_COEF [SINE_TERMS] = '{
    32'sd1686629713, -32'sd693598668, 32'sd85569306, -32'sd5026994,
    32'sd172272, -32'sd3864, 32'sd61
  };

  // Input register, square, one stage per Horner step, final multiply,
  // quadrant fold, two product stages
  localparam int LATENCY = SINE_TERMS + 5;

  // Quadrant of a binary angle
  typedef enum logic [1:0] {
    QUAD_I   = 2'd0,
    QUAD_II  = 2'd1,
    QUAD_III = 2'd2,
    QUAD_IV  = 2'd3
  } quad_t;

  typedef struct packed {
    logic signed [ANGLE_BITS-1:0] angle_x;
    logic signed [ANGLE_BITS-1:0] angle_y;
    logic signed [ANGLE_BITS-1:0] angle_z;
  } angles_t;

  typedef struct packed {
    logic signed [ENTRY_BITS-1:0] rot_00;
    logic signed [ENTRY_BITS-1:0] rot_01;
    logic signed [ENTRY_BITS-1:0] rot_02;
    logic signed [ENTRY_BITS-1:0] rot_10;
    logic signed [ENTRY_BITS-1:0] rot_11;
    logic signed [ENTRY_BITS-1:0] rot_12;
    logic signed [ENTRY_BITS-1:0] rot_20;
    logic signed [ENTRY_BITS-1:0] rot_21;
    logic signed [ENTRY_BITS-1:0] rot_22;
  } matrix_t;

endpackage

`default_nettype wire

@@ src/euler_rotation_matrix_top.sv @@
// A word taken with start moves through the erm_pkg::LATENCY registers, the
// input register, square, six Horner steps, final multiply, quadrant fold and
// two product stages, and then shows on matrix with done high. Throughput: one
// word per cycle; busy never rises and the result side has no stall. Reset
// clears only the valid bits, so nothing in flight is delivered after rst.
// Top level of the Euler-angle (YZX) rotation matrix pipeline.
// Uses erm_pkg for word types, sine coefficients and the pipeline stage count.
`timescale 1ns / 1ps
`default_nettype none

module euler_rotation_matrix_top (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire erm_pkg::angles_t angles,
  output logic                 done,
  output erm_pkg::matrix_t     matrix
);

  localparam int ANGLES     = 3;
  localparam int LANES      = 2 * ANGLES;
  localparam int HORNER     = erm_pkg::SINE_TERMS - 1;
  localparam int LAST_H     = HORNER + 1;
  localparam int PHASE_FRAC = 30;
  localparam int EB         = erm_pkg::ENTRY_BITS;
  localparam logic signed [31:0] Q30_ONE = 32'sd1 <<< PHASE_FRAC;
  localparam logic signed [EB:0] SUM_ONE = {1'b0, erm_pkg::ENTRY_ONE};

  typedef struct packed {
    logic           zero;
    erm_pkg::quad_t quad;
  } tag_t;

  // Round to nearest, ties away from zero, dropping sh fraction bits
  function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                     input int unsigned sh);
    logic signed [63:0] half;
    half = 64'sd1 <<< (sh - 1);
    if (sh == 0) begin
      return v;
    end
    return (v + half - $signed({63'd0, v[63]})) >>> sh;
  endfunction

  // Product of two output-format values, rounded back to the output format
  function automatic logic signed [EB-1:0] mul_frac(input logic signed [EB-1:0] a,
                                                    input logic signed [EB-1:0] b);
    logic signed [2*EB-1:0] prod;
    logic signed [63:0]     rs;
    prod = a * b;
    rs   = round_shift(64'(prod), erm_pkg::FRAC_BITS);
    return rs[EB-1:0];
  endfunction

  // Saturate a widened sum to plus or minus one
  function automatic logic signed [EB-1:0] sat_entry(input logic signed [EB:0] v);
    logic signed [EB:0] r;
    r = v;
    if (v > SUM_ONE) begin
      r = SUM_ONE;
    end else if (v < -SUM_ONE) begin
      r = -SUM_ONE;
    end
    return r[EB-1:0];
  endfunction

  // Pipeline registers; stage index 0 is the input register
  logic [erm_pkg::LATENCY-1:0] vld;
  logic signed [31:0] u_pipe   [0:LAST_H][LANES];
  logic signed [31:0] u2_pipe  [1:HORNER][LANES];
  logic signed [31:0] acc_pipe [2:LAST_H][LANES];
  tag_t               tag_pipe [0:LAST_H+1][ANGLES];
  logic signed [31:0] f_s      [LANES];
  logic signed [EB-1:0] q_sin [ANGLES];
  logic signed [EB-1:0] q_cos [ANGLES];
  logic signed [EB-1:0] p_cxcy, p_cxsy, p_sxcy, p_sxsy, p_sz;
  logic signed [EB-1:0] p_cycz, p_cxcz, p_sxcz_n, p_sycz_n;

  // Combinational stage results
  logic [erm_pkg::ANGLE_BITS-1:0] angle_in [ANGLES];
  logic signed [31:0] a_u     [LANES];
  tag_t               a_tag   [ANGLES];
  logic signed [31:0] b_u2    [LANES];
  logic signed [31:0] h_acc   [2:LAST_H][LANES];
  logic signed [31:0] f_val   [LANES];
  logic signed [EB-1:0] q_sin_next [ANGLES];
  logic signed [EB-1:0] q_cos_next [ANGLES];
  erm_pkg::matrix_t   matrix_next;

  // Never hold off a word; one enters every cycle
  assign busy = 1'b0;
  assign done = vld[erm_pkg::LATENCY-1];

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[erm_pkg::LATENCY-2:0], start && !busy};
    end
  end

  // Split each angle into quadrant and position u, and form 1 - u
  always_comb begin
    logic [31:0] phase;
    angle_in[0] = angles.angle_x;
    angle_in[1] = angles.angle_y;
    angle_in[2] = angles.angle_z;
    for (int k = 0; k < ANGLES; k++) begin
      phase            = {angle_in[k], {(32 - erm_pkg::ANGLE_BITS){1'b0}}};
      a_u[2*k]         = {2'b00, phase[29:0]};
      a_u[2*k+1]       = Q30_ONE - {2'b00, phase[29:0]};
      a_tag[k].zero    = (phase[29:0] == '0);
      a_tag[k].quad    = erm_pkg::quad_t'(phase[31:30]);
    end
  end

  // Square the position in Q30
  always_comb begin
    logic signed [63:0] prod;
    logic signed [63:0] rs;
    for (int l = 0; l < LANES; l++) begin
      prod    = u_pipe[0][l] * u_pipe[0][l];
      rs      = round_shift(prod, PHASE_FRAC);
      b_u2[l] = $signed(rs[31:0]);
    end
  end

  // Horner steps, one per stage, highest coefficient first
  always_comb begin
    logic signed [63:0] prod;
    logic signed [63:0] rs;
    for (int l = 0; l < LANES; l++) begin
      prod        = erm_pkg::SINE_COEF[HORNER] * u2_pipe[1][l];
      rs          = round_shift(prod, PHASE_FRAC);
      h_acc[2][l] = erm_pkg::SINE_COEF[HORNER-1] + $signed(rs[31:0]);
      for (int s = 3; s <= LAST_H; s++) begin
        prod        = acc_pipe[s-1][l] * u2_pipe[s-1][l];
        rs          = round_shift(prod, PHASE_FRAC);
        h_acc[s][l] = erm_pkg::SINE_COEF[LAST_H-s] + $signed(rs[31:0]);
      end
    end
  end

  // Final multiply by u, clamp to 0..1, force the exact ends
  always_comb begin
    logic signed [63:0] prod;
    logic signed [63:0] rs;
    for (int l = 0; l < LANES; l++) begin
      prod = acc_pipe[LAST_H][l] * u_pipe[LAST_H][l];
      rs   = round_shift(prod, PHASE_FRAC);
      if (rs < 64'sd0) begin
        f_val[l] = '0;
      end else if (rs > 64'(Q30_ONE)) begin
        f_val[l] = Q30_ONE;
      end else begin
        f_val[l] = $signed(rs[31:0]);
      end
      if (tag_pipe[LAST_H][l >> 1].zero) begin
        f_val[l] = l[0] ? Q30_ONE : 32'sd0;
      end
    end
  end

  // Fold by quadrant and round to the output format
  always_comb begin
    logic signed [31:0] sv;
    logic signed [31:0] cv;
    logic signed [63:0] rs;
    for (int k = 0; k < ANGLES; k++) begin
      unique case (tag_pipe[LAST_H+1][k].quad)
        erm_pkg::QUAD_I: begin
          sv = f_s[2*k];
          cv = f_s[2*k+1];
        end
        erm_pkg::QUAD_II: begin
          sv = f_s[2*k+1];
          cv = -f_s[2*k];
        end
        erm_pkg::QUAD_III: begin
          sv = -f_s[2*k];
          cv = -f_s[2*k+1];
        end
        erm_pkg::QUAD_IV: begin
          sv = -f_s[2*k+1];
          cv = f_s[2*k];
        end
      endcase
      rs            = round_shift(64'(sv), PHASE_FRAC - erm_pkg::FRAC_BITS);
      q_sin_next[k] = rs[EB-1:0];
      rs            = round_shift(64'(cv), PHASE_FRAC - erm_pkg::FRAC_BITS);
      q_cos_next[k] = rs[EB-1:0];
    end
  end

  // Second products, sums and saturation for the output word
  always_comb begin
    matrix_next.rot_00 = p_cycz;
    matrix_next.rot_01 = sat_entry((EB+1)'(p_sxsy) - (EB+1)'(mul_frac(p_cxcy, p_sz)));
    matrix_next.rot_02 = sat_entry((EB+1)'(mul_frac(p_sxcy, p_sz)) + (EB+1)'(p_cxsy));
    matrix_next.rot_10 = p_sz;
    matrix_next.rot_11 = p_cxcz;
    matrix_next.rot_12 = p_sxcz_n;
    matrix_next.rot_20 = p_sycz_n;
    matrix_next.rot_21 = sat_entry((EB+1)'(mul_frac(p_cxsy, p_sz)) + (EB+1)'(p_sxcy));
    matrix_next.rot_22 = sat_entry((EB+1)'(p_cxcy) - (EB+1)'(mul_frac(p_sxsy, p_sz)));
  end

  // Shift the data stages every cycle
  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      u_pipe[0][l]  <= a_u[l];
      u2_pipe[1][l] <= b_u2[l];
      f_s[l]        <= f_val[l];
      for (int s = 1; s <= LAST_H; s++) begin
        u_pipe[s][l] <= u_pipe[s-1][l];
      end
      for (int s = 2; s <= HORNER; s++) begin
        u2_pipe[s][l] <= u2_pipe[s-1][l];
      end
      for (int s = 2; s <= LAST_H; s++) begin
        acc_pipe[s][l] <= h_acc[s][l];
      end
    end
    for (int k = 0; k < ANGLES; k++) begin
      tag_pipe[0][k] <= a_tag[k];
      for (int s = 1; s <= LAST_H + 1; s++) begin
        tag_pipe[s][k] <= tag_pipe[s-1][k];
      end
      q_sin[k] <= q_sin_next[k];
      q_cos[k] <= q_cos_next[k];
    end
    // First products; index 0 is x, 1 is y, 2 is z
    p_cxcy   <= mul_frac(q_cos[0], q_cos[1]);
    p_cxsy   <= mul_frac(q_cos[0], q_sin[1]);
    p_sxcy   <= mul_frac(q_sin[0], q_cos[1]);
    p_sxsy   <= mul_frac(q_sin[0], q_sin[1]);
    p_sz     <= q_sin[2];
    p_cycz   <= mul_frac(q_cos[1], q_cos[2]);
    p_cxcz   <= mul_frac(q_cos[0], q_cos[2]);
    p_sxcz_n <= -mul_frac(q_sin[0], q_cos[2]);
    p_sycz_n <= -mul_frac(q_sin[1], q_cos[2]);
    matrix   <= matrix_next;
  end

endmodule

`default_nettype wire

@@ src/erm_checker.sv @@
// Port-level checker for the rotation matrix pipeline, bound to the top level.
// Uses erm_pkg for the pipeline stage count and the value of one.
`timescale 1ns / 1ps
`default_nettype none

module erm_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             start,
  input wire logic             busy,
  input wire erm_pkg::angles_t angles,
  input wire logic             done,
  input wire erm_pkg::matrix_t matrix
);

  localparam int LAT = erm_pkg::LATENCY;

  // Every accepted word comes out on done once it has crossed the pipeline
  a_word_out: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LAT done)
    else $error("accepted word not delivered after pipeline latency");

  // No word appears on done without a matching accepted word
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result word without matching accepted word");

  // Saturated entries stay within plus or minus one
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (matrix.rot_01 <= erm_pkg::ENTRY_ONE && matrix.rot_01 >= -erm_pkg::ENTRY_ONE &&
              matrix.rot_02 <= erm_pkg::ENTRY_ONE && matrix.rot_02 >= -erm_pkg::ENTRY_ONE &&
              matrix.rot_21 <= erm_pkg::ENTRY_ONE && matrix.rot_21 >= -erm_pkg::ENTRY_ONE &&
              matrix.rot_22 <= erm_pkg::ENTRY_ONE && matrix.rot_22 >= -erm_pkg::ENTRY_ONE))
    else $error("matrix entry out of range");

  // Zero angles give the identity matrix
  a_identity: assert property (@(posedge clk) disable iff (rst)
    done && $past(start && !busy && angles == '0, LAT) |->
      (matrix.rot_00 == erm_pkg::ENTRY_ONE && matrix.rot_11 == erm_pkg::ENTRY_ONE &&
       matrix.rot_22 == erm_pkg::ENTRY_ONE && matrix.rot_01 == '0 &&
       matrix.rot_02 == '0 && matrix.rot_10 == '0 && matrix.rot_12 == '0 &&
       matrix.rot_20 == '0 && matrix.rot_21 == '0))
    else $error("zero angles did not give identity");

endmodule

bind euler_rotation_matrix_top erm_checker u_erm_checker (.*);

`default_nettype wire
